>>> rtl/pfe_pkg.sv
// shared types, constants and arithmetic helpers for the path frenet error finder
// no dependencies
package pfe_pkg;

  localparam int WAYPOINTS    = 17;
  localparam int MAX_SEGMENTS = 16;
  localparam int QDepth       = 2;
  localparam int CordicSteps  = 16;
  localparam int AngW         = 23;
  localparam int HdgW         = 19;
  localparam int PosW         = 32;

  localparam logic signed [AngW-1:0] PiQ     = 23'sd205887;
  localparam logic signed [AngW-1:0] TwoPiQ  = 23'sd411775;
  localparam logic signed [AngW-1:0] HalfPiQ = 23'sd102944;
  localparam logic signed [32:0] CordicGain  = 33'sd652032874;
  localparam logic [16:0] ParamOne           = 17'd65536;

  typedef enum logic {
    KIND_WAYPOINT,
    KIND_POSE
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [HdgW-1:0] hdg;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t head;
  } queue_head_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_DIFF, S_LEN0, S_LEN1, S_DOT0, S_DOT1, S_DOT2,
    S_DIV_INIT, S_DIV, S_W0, S_W1, S_W2, S_W3, S_D0, S_D1, S_D2, S_CMP,
    S_COR_INIT, S_COR, S_EY0, S_EY1, S_EY2, S_EY3, S_NEXT, S_DONE
  } state_e;

  function automatic logic signed [AngW-1:0] atan_q16(input logic [3:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      4'd0:    r = 23'sd51472;
      4'd1:    r = 23'sd30385;
      4'd2:    r = 23'sd16055;
      4'd3:    r = 23'sd8150;
      4'd4:    r = 23'sd4091;
      4'd5:    r = 23'sd2047;
      4'd6:    r = 23'sd1024;
      4'd7:    r = 23'sd512;
      4'd8:    r = 23'sd256;
      4'd9:    r = 23'sd128;
      4'd10:   r = 23'sd64;
      4'd11:   r = 23'sd32;
      4'd12:   r = 23'sd16;
      4'd13:   r = 23'sd8;
      4'd14:   r = 23'sd4;
      default: r = 23'sd2;
    endcase
    return r;
  endfunction

  // input stays within about three turns, two passes each way suffice
  function automatic logic signed [AngW-1:0] wrap_angle(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] r;
    r = a;
    for (int k = 0; k < 2; k++) begin
      if (r > PiQ) r = r - TwoPiQ;
    end
    for (int k = 0; k < 2; k++) begin
      if (r < -PiQ) r = r + TwoPiQ;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_diff(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sd2147483647;
    else if (v < -36'sd2147483647) r = -32'sd2147483647;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (!v[63]) r = (v + 64'sd32768) >>> 16;
    else r = -((-v + 64'sd32768) >>> 16);
    return r;
  endfunction

  function automatic logic signed [31:0] rnd30_sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic signed [31:0] o;
    if (!v[63]) r = (v + 64'sd536870912) >>> 30;
    else r = -((-v + 64'sd536870912) >>> 30);
    if (r > 64'sd2147483647) o = 32'sh7fffffff;
    else if (r < -64'sd2147483648) o = 32'sh80000000;
    else o = r[31:0];
    return o;
  endfunction

endpackage

>>> rtl/pfe_ram.sv
// generic single write port ram with registered read
// no dependencies
module pfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/pfe_front.sv
// front end: takes requests, classifies them and queues them for the back end
// depends on pfe_pkg
module pfe_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           req_type_i,
  input  logic signed [pfe_pkg::PosW-1:0] pos_x_i,
  input  logic signed [pfe_pkg::PosW-1:0] pos_y_i,
  input  logic signed [pfe_pkg::HdgW-1:0] heading_i,
  input  logic                           pop_i,
  output pfe_pkg::queue_head_t           head_o
);

  localparam int PtrW = $clog2(pfe_pkg::QDepth);
  localparam int CntW = $clog2(pfe_pkg::QDepth + 1);

  pfe_pkg::item_t    slot_q [pfe_pkg::QDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push;
  logic              pop;
  pfe_pkg::item_t    in_item;

  assign busy_o = (cnt_q == CntW'(pfe_pkg::QDepth));
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != '0);

  always_comb begin
    in_item.kind = req_type_i ? pfe_pkg::KIND_POSE : pfe_pkg::KIND_WAYPOINT;
    in_item.x    = pos_x_i;
    in_item.y    = pos_y_i;
    in_item.hdg  = heading_i;
  end

  assign head_o.avail = (cnt_q != '0);
  assign head_o.head  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PtrW'(pfe_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop) rptr_q <= (rptr_q == PtrW'(pfe_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/pfe_back.sv
// back end: waypoint store, segment search sequencer with shared multiplier,
// divider and cordic; depends on pfe_pkg and pfe_ram
module pfe_back #(
  parameter int WAYPOINTS    = pfe_pkg::WAYPOINTS,
  parameter int MAX_SEGMENTS = pfe_pkg::MAX_SEGMENTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfe_pkg::queue_head_t            head_i,
  output logic                            pop_o,
  output logic                            valid_o,
  output logic signed [31:0]              lateral_error_o,
  output logic signed [pfe_pkg::HdgW-1:0] heading_error_o,
  output logic                            status_o
);

  localparam int CntW  = $clog2(WAYPOINTS + 1);
  localparam int AddrW = $clog2(WAYPOINTS);
  localparam int RamW  = 2 * pfe_pkg::PosW + pfe_pkg::HdgW;
  localparam int AngW  = pfe_pkg::AngW;

  pfe_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, nseg_q, seg_q;
  logic [3:0]       step_q;
  pfe_pkg::item_t   pose_q;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [RamW-1:0]        ram_wdata, ram_rdata;
  logic signed [31:0]     rd_x, rd_y;
  logic signed [pfe_pkg::HdgW-1:0] rd_h;

  logic signed [31:0]     ax_q, ay_q;
  logic signed [pfe_pkg::HdgW-1:0] h0_q;
  logic signed [31:0]     abx_q, aby_q, apx_q, apy_q, dx_q, dy_q;
  logic signed [AngW-1:0] dpsi_q, wpsi_q, z_q;
  logic [63:0]            len2_q, d2_q, best_q;
  logic signed [63:0]     dot_q, prod_q, ey_q;
  logic [63:0]            rem_q;
  logic [16:0]            t_q;
  logic signed [35:0]     wx_q, wy_q;
  logic signed [32:0]     cx_q, cy_q;
  logic                   neg_q, have_q;

  logic signed [32:0]     mul_a, mul_b;
  logic signed [65:0]     mul_full;
  logic [64:0]            rem_sh;
  logic signed [32:0]     cx_sh, cy_sh, cos_v, sin_v;
  logic signed [AngW-1:0] zw;
  logic                   seg_last;
  logic                   is_pose;

  logic                            valid_q, status_q;
  logic signed [31:0]              lat_q;
  logic signed [pfe_pkg::HdgW-1:0] hdg_q;

  pfe_ram #(
    .Width (RamW),
    .Depth (WAYPOINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[RamW-1 -: 32];
  assign rd_y = ram_rdata[pfe_pkg::HdgW +: 32];
  assign rd_h = ram_rdata[pfe_pkg::HdgW-1:0];

  assign is_pose  = (head_i.head.kind == pfe_pkg::KIND_POSE);
  assign seg_last = ((seg_q + 1'b1) >= nseg_q);
  assign mul_full = mul_a * mul_b;
  assign rem_sh   = {rem_q, 1'b0};
  assign cx_sh    = cx_q >>> step_q;
  assign cy_sh    = cy_q >>> step_q;
  assign cos_v    = neg_q ? -cx_q : cx_q;
  assign sin_v    = neg_q ? -cy_q : cy_q;
  assign zw       = pfe_pkg::wrap_angle(wpsi_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfe_pkg::S_IDLE: begin
        if (head_i.avail && is_pose && cnt_q >= CntW'(2)) state_d = pfe_pkg::S_RD_A;
      end
      pfe_pkg::S_RD_A:     state_d = pfe_pkg::S_RD_B;
      pfe_pkg::S_RD_B:     state_d = pfe_pkg::S_DIFF;
      pfe_pkg::S_DIFF:     state_d = pfe_pkg::S_LEN0;
      pfe_pkg::S_LEN0:     state_d = pfe_pkg::S_LEN1;
      pfe_pkg::S_LEN1:     state_d = pfe_pkg::S_DOT0;
      pfe_pkg::S_DOT0:     state_d = pfe_pkg::S_DOT1;
      pfe_pkg::S_DOT1:     state_d = pfe_pkg::S_DOT2;
      pfe_pkg::S_DOT2:     state_d = pfe_pkg::S_DIV_INIT;
      pfe_pkg::S_DIV_INIT: begin
        if (len2_q == '0 || dot_q <= 0 || $unsigned(dot_q) >= len2_q) state_d = pfe_pkg::S_W0;
        else state_d = pfe_pkg::S_DIV;
      end
      pfe_pkg::S_DIV: begin
        if (step_q == 4'(pfe_pkg::CordicSteps - 1)) state_d = pfe_pkg::S_W0;
      end
      pfe_pkg::S_W0:       state_d = pfe_pkg::S_W1;
      pfe_pkg::S_W1:       state_d = pfe_pkg::S_W2;
      pfe_pkg::S_W2:       state_d = pfe_pkg::S_W3;
      pfe_pkg::S_W3:       state_d = pfe_pkg::S_D0;
      pfe_pkg::S_D0:       state_d = pfe_pkg::S_D1;
      pfe_pkg::S_D1:       state_d = pfe_pkg::S_D2;
      pfe_pkg::S_D2:       state_d = pfe_pkg::S_CMP;
      pfe_pkg::S_CMP: begin
        if (!have_q || d2_q < best_q) state_d = pfe_pkg::S_COR_INIT;
        else state_d = pfe_pkg::S_NEXT;
      end
      pfe_pkg::S_COR_INIT: state_d = pfe_pkg::S_COR;
      pfe_pkg::S_COR: begin
        if (step_q == 4'(pfe_pkg::CordicSteps - 1)) state_d = pfe_pkg::S_EY0;
      end
      pfe_pkg::S_EY0:      state_d = pfe_pkg::S_EY1;
      pfe_pkg::S_EY1:      state_d = pfe_pkg::S_EY2;
      pfe_pkg::S_EY2:      state_d = pfe_pkg::S_EY3;
      pfe_pkg::S_EY3:      state_d = pfe_pkg::S_NEXT;
      pfe_pkg::S_NEXT: begin
        state_d = seg_last ? pfe_pkg::S_DONE : pfe_pkg::S_RD_A;
      end
      pfe_pkg::S_DONE:     state_d = pfe_pkg::S_IDLE;
      default:             state_d = pfe_pkg::S_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_wdata = {head_i.head.x, head_i.head.y, head_i.head.hdg};
    ram_raddr = seg_q[AddrW-1:0];
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      pfe_pkg::S_IDLE: begin
        pop_o  = head_i.avail;
        ram_we = head_i.avail && !is_pose && (cnt_q < CntW'(WAYPOINTS));
      end
      pfe_pkg::S_RD_B: ram_raddr = AddrW'(seg_q + 1'b1);
      pfe_pkg::S_LEN0: begin
        mul_a = 33'(abx_q);
        mul_b = 33'(abx_q);
      end
      pfe_pkg::S_LEN1: begin
        mul_a = 33'(aby_q);
        mul_b = 33'(aby_q);
      end
      pfe_pkg::S_DOT0: begin
        mul_a = 33'(apx_q);
        mul_b = 33'(abx_q);
      end
      pfe_pkg::S_DOT1: begin
        mul_a = 33'(apy_q);
        mul_b = 33'(aby_q);
      end
      pfe_pkg::S_W0: begin
        mul_a = $signed({16'd0, t_q});
        mul_b = 33'(abx_q);
      end
      pfe_pkg::S_W1: begin
        mul_a = $signed({16'd0, t_q});
        mul_b = 33'(aby_q);
      end
      pfe_pkg::S_W2: begin
        mul_a = $signed({16'd0, t_q});
        mul_b = 33'(dpsi_q);
      end
      pfe_pkg::S_D0: begin
        mul_a = 33'(dx_q);
        mul_b = 33'(dx_q);
      end
      pfe_pkg::S_D1: begin
        mul_a = 33'(dy_q);
        mul_b = 33'(dy_q);
      end
      pfe_pkg::S_EY0: begin
        mul_a = cos_v;
        mul_b = 33'(dy_q);
      end
      pfe_pkg::S_EY1: begin
        mul_a = sin_v;
        mul_b = 33'(dx_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfe_pkg::S_IDLE;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      have_q   <= 1'b0;
      step_q   <= '0;
      seg_q    <= '0;
      nseg_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      case (state_q)
        pfe_pkg::S_IDLE: begin
          if (head_i.avail) begin
            if (!is_pose) begin
              if (cnt_q < CntW'(WAYPOINTS)) cnt_q <= cnt_q + 1'b1;
            end else if (cnt_q < CntW'(2)) begin
              cnt_q   <= '0;
              valid_q <= 1'b1;
            end else begin
              seg_q  <= '0;
              have_q <= 1'b0;
              if (32'(cnt_q) - 32'd1 > 32'(MAX_SEGMENTS)) nseg_q <= CntW'(MAX_SEGMENTS);
              else nseg_q <= cnt_q - 1'b1;
            end
          end
        end
        pfe_pkg::S_DIV_INIT: step_q <= '0;
        pfe_pkg::S_DIV:      step_q <= step_q + 1'b1;
        pfe_pkg::S_COR_INIT: step_q <= '0;
        pfe_pkg::S_COR:      step_q <= step_q + 1'b1;
        pfe_pkg::S_CMP: begin
          if (!have_q || d2_q < best_q) have_q <= 1'b1;
        end
        pfe_pkg::S_NEXT: begin
          if (!seg_last) seg_q <= seg_q + 1'b1;
        end
        pfe_pkg::S_DONE: begin
          cnt_q   <= '0;
          valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    case (state_q)
      pfe_pkg::S_IDLE: begin
        if (head_i.avail && is_pose) begin
          pose_q   <= head_i.head;
          lat_q    <= '0;
          hdg_q    <= '0;
          status_q <= (cnt_q < CntW'(2));
        end
      end
      pfe_pkg::S_RD_B: begin
        ax_q <= rd_x;
        ay_q <= rd_y;
        h0_q <= rd_h;
      end
      pfe_pkg::S_DIFF: begin
        abx_q  <= pfe_pkg::sat_diff(36'(rd_x) - 36'(ax_q));
        aby_q  <= pfe_pkg::sat_diff(36'(rd_y) - 36'(ay_q));
        apx_q  <= pfe_pkg::sat_diff(36'(pose_q.x) - 36'(ax_q));
        apy_q  <= pfe_pkg::sat_diff(36'(pose_q.y) - 36'(ay_q));
        dpsi_q <= pfe_pkg::wrap_angle(AngW'(rd_h) - AngW'(h0_q));
      end
      pfe_pkg::S_LEN1: len2_q <= $unsigned(prod_q);
      pfe_pkg::S_DOT0: len2_q <= len2_q + $unsigned(prod_q);
      pfe_pkg::S_DOT1: dot_q <= prod_q;
      pfe_pkg::S_DOT2: dot_q <= dot_q + prod_q;
      pfe_pkg::S_DIV_INIT: begin
        rem_q <= $unsigned(dot_q);
        if (len2_q == '0 || dot_q <= 0) t_q <= '0;
        else if ($unsigned(dot_q) >= len2_q) t_q <= pfe_pkg::ParamOne;
        else t_q <= '0;
      end
      pfe_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, len2_q}) begin
          rem_q <= 64'(rem_sh - {1'b0, len2_q});
          t_q   <= {t_q[15:0], 1'b1};
        end else begin
          rem_q <= rem_sh[63:0];
          t_q   <= {t_q[15:0], 1'b0};
        end
      end
      pfe_pkg::S_W1: wx_q <= 36'(ax_q) + 36'(pfe_pkg::rnd16(prod_q));
      pfe_pkg::S_W2: wy_q <= 36'(ay_q) + 36'(pfe_pkg::rnd16(prod_q));
      pfe_pkg::S_W3: begin
        wpsi_q <= AngW'(h0_q) + AngW'(pfe_pkg::rnd16(prod_q));
        dx_q   <= pfe_pkg::sat_diff(36'(pose_q.x) - wx_q);
        dy_q   <= pfe_pkg::sat_diff(36'(pose_q.y) - wy_q);
      end
      pfe_pkg::S_D1: d2_q <= $unsigned(prod_q);
      pfe_pkg::S_D2: d2_q <= d2_q + $unsigned(prod_q);
      pfe_pkg::S_CMP: begin
        if (!have_q || d2_q < best_q) best_q <= d2_q;
      end
      pfe_pkg::S_COR_INIT: begin
        cx_q <= pfe_pkg::CordicGain;
        cy_q <= '0;
        if (zw > pfe_pkg::HalfPiQ) begin
          z_q   <= zw - pfe_pkg::PiQ;
          neg_q <= 1'b1;
        end else if (zw < -pfe_pkg::HalfPiQ) begin
          z_q   <= zw + pfe_pkg::PiQ;
          neg_q <= 1'b1;
        end else begin
          z_q   <= zw;
          neg_q <= 1'b0;
        end
      end
      pfe_pkg::S_COR: begin
        if (!z_q[AngW-1]) begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          z_q  <= z_q - pfe_pkg::atan_q16(step_q);
        end else begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          z_q  <= z_q + pfe_pkg::atan_q16(step_q);
        end
      end
      pfe_pkg::S_EY1: ey_q <= prod_q;
      pfe_pkg::S_EY2: ey_q <= ey_q - prod_q;
      pfe_pkg::S_EY3: begin
        lat_q <= pfe_pkg::rnd30_sat(ey_q);
        hdg_q <= pfe_pkg::HdgW'(pfe_pkg::wrap_angle(AngW'(pose_q.hdg) - wpsi_q));
      end
      default: ;
    endcase
  end

  assign valid_o         = valid_q;
  assign lateral_error_o = lat_q;
  assign heading_error_o = hdg_q;
  assign status_o        = status_q;

endmodule

>>> rtl/path_frenet_error_finder.sv
// top level of the path frenet error finder
// depends on pfe_pkg, pfe_front, pfe_back (and pfe_ram through pfe_back)
//
// Usage: a request is taken at a rising edge with start_i high and busy_o low.
// req_type_i low appends a waypoint (pos_x_i, pos_y_i, heading_i) to the store;
// a full store drops it. req_type_i high gives the vehicle pose and runs the
// nearest segment search over min(count-1, MAX_SEGMENTS) segments; every pose
// clears the waypoint count. Each pose gives one result, shown on
// lateral_error_o, heading_error_o and status_o for one cycle with valid_o high.
// status_o high means fewer than two waypoints were loaded; errors are then zero.
// Requests go through a two entry queue, so busy_o rises only when it is full.
// A waypoint is written to the store from the queue head; a pose with too few
// waypoints is answered without a search. Each segment reads two waypoints,
// forms the length and dot products, divides (not when the projection clamps),
// interpolates and measures the distance; the cordic rotation and error steps
// follow a new best. Steps share the multiplier; divider and cordic take 16 steps.
// Reset clears the queue, the waypoint count and any search in progress.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module path_frenet_error_finder #(
  parameter int WAYPOINTS    = pfe_pkg::WAYPOINTS,
  parameter int MAX_SEGMENTS = pfe_pkg::MAX_SEGMENTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic signed [pfe_pkg::PosW-1:0] pos_x_i,
  input  logic signed [pfe_pkg::PosW-1:0] pos_y_i,
  input  logic signed [pfe_pkg::HdgW-1:0] heading_i,
  output logic                            valid_o,
  output logic signed [pfe_pkg::PosW-1:0] lateral_error_o,
  output logic signed [pfe_pkg::HdgW-1:0] heading_error_o,
  output logic                            status_o
);

  pfe_pkg::queue_head_t head;
  logic                 pop;

  pfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_type_i (req_type_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .heading_i  (heading_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  pfe_back #(
    .WAYPOINTS    (WAYPOINTS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .valid_o         (valid_o),
    .lateral_error_o (lateral_error_o),
    .heading_error_o (heading_error_o),
    .status_o        (status_o)
  );

endmodule

>>> verif/path_frenet_error_finder_tb.sv
// self-checking testbench for path_frenet_error_finder: waypoint loads and pose searches
// depends on pfe_pkg and the rtl top level; predicts every result in-bench and compares
`timescale 1ns / 100ps

module path_frenet_error_finder_tb;

  typedef struct {
    pfe_pkg::kind_e                  kind;
    logic signed [pfe_pkg::PosW-1:0] x;
    logic signed [pfe_pkg::PosW-1:0] y;
    logic signed [pfe_pkg::HdgW-1:0] hdg;
  } request_t;

  typedef struct {
    logic signed [pfe_pkg::PosW-1:0] lat;
    logic signed [pfe_pkg::HdgW-1:0] hdg;
    logic                            st;
  } frenet_t;

  localparam longint DMax = 64'sd2147483647;
  localparam int     NumRandom = 1530;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic                            busy_o;
  logic                            req_type_i = 1'b0;
  logic signed [pfe_pkg::PosW-1:0] pos_x_i = '0;
  logic signed [pfe_pkg::PosW-1:0] pos_y_i = '0;
  logic signed [pfe_pkg::HdgW-1:0] heading_i = '0;
  logic                            valid_o;
  logic signed [pfe_pkg::PosW-1:0] lateral_error_o;
  logic signed [pfe_pkg::HdgW-1:0] heading_error_o;
  logic                            status_o;

  request_t pending_q[$];
  frenet_t  frenet_q[$];
  longint   wp_x[pfe_pkg::WAYPOINTS];
  longint   wp_y[pfe_pkg::WAYPOINTS];
  longint   wp_h[pfe_pkg::WAYPOINTS];
  int       wp_count = 0;
  int       mismatches = 0;
  int       n_results = 0;
  int       n_short = 0;
  int       n_waypoints = 0;
  int       n_poses = 0;
  int       gap_cnt = 0;
  bit       no_idle = 1'b0;
  bit       taken = 1'b0;

  path_frenet_error_finder uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint sat_d(longint v);
    if (v > DMax) return DMax;
    if (v < -DMax) return -DMax;
    return v;
  endfunction

  function automatic longint round_sh(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint wrap_ang(longint a);
    while (a > 205887) a -= 411775;
    while (a < -205887) a += 411775;
    return a;
  endfunction

  function automatic void rotate_unit(longint ang, output longint s, output longint c);
    longint cx, cy, z, xs, ys, at;
    bit neg;
    cx = 652032874;
    cy = 0;
    z = wrap_ang(ang);
    neg = 1'b0;
    if (z > 102944) begin
      z -= 205887;
      neg = 1'b1;
    end else if (z < -102944) begin
      z += 205887;
      neg = 1'b1;
    end
    for (int i = 0; i < pfe_pkg::CordicSteps; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      at = longint'(pfe_pkg::atan_q16(i[3:0]));
      if (z >= 0) begin
        cx -= ys;
        cy += xs;
        z -= at;
      end else begin
        cx += ys;
        cy -= xs;
        z += at;
      end
    end
    c = neg ? -cx : cx;
    s = neg ? -cy : cy;
  endfunction

  function automatic longint proj_param(longint dot, longint len2);
    longint unsigned r, q, l;
    if (len2 == 0 || dot <= 0) return 0;
    if (dot >= len2) return 65536;
    r = dot;
    l = len2;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= l) begin
        r -= l;
        q |= 1;
      end
    end
    return longint'(q);
  endfunction

  function automatic frenet_t nearest_error(longint px, longint py, longint th);
    frenet_t res;
    longint ax, ay, abx, aby, apx, apy, len2, dot, t, h0, dpsi, wpsi, dx, dy, d2;
    longint best_d2, s, c, ey, ep;
    bit have;
    int nseg;
    res.lat = '0;
    res.hdg = '0;
    res.st = 1'b0;
    have = 1'b0;
    best_d2 = 0;
    nseg = wp_count - 1;
    if (nseg > pfe_pkg::MAX_SEGMENTS) nseg = pfe_pkg::MAX_SEGMENTS;
    for (int i = 0; i < nseg && i + 1 < pfe_pkg::WAYPOINTS; i++) begin
      ax = wp_x[i];
      ay = wp_y[i];
      abx = sat_d(wp_x[i+1] - ax);
      aby = sat_d(wp_y[i+1] - ay);
      apx = sat_d(px - ax);
      apy = sat_d(py - ay);
      len2 = abx * abx + aby * aby;
      dot = apx * abx + apy * aby;
      t = proj_param(dot, len2);
      h0 = wp_h[i];
      dpsi = wrap_ang(wp_h[i+1] - h0);
      wpsi = h0 + round_sh(t * dpsi, 16);
      dx = sat_d(px - (ax + round_sh(t * abx, 16)));
      dy = sat_d(py - (ay + round_sh(t * aby, 16)));
      d2 = dx * dx + dy * dy;
      if (!have || d2 < best_d2) begin
        have = 1'b1;
        best_d2 = d2;
        rotate_unit(wpsi, s, c);
        ey = round_sh(c * dy - s * dx, 30);
        if (ey > 64'sd2147483647) ey = 64'sd2147483647;
        if (ey < -64'sd2147483648) ey = -64'sd2147483648;
        res.lat = ey[31:0];
        ep = wrap_ang(th - wpsi);
        res.hdg = ep[18:0];
      end
    end
    return res;
  endfunction

  function automatic void apply_request(request_t r);
    frenet_t res;
    if (r.kind == pfe_pkg::KIND_WAYPOINT) begin
      n_waypoints++;
      if (wp_count < pfe_pkg::WAYPOINTS) begin
        wp_x[wp_count] = r.x;
        wp_y[wp_count] = r.y;
        wp_h[wp_count] = r.hdg;
        wp_count++;
      end
      return;
    end
    n_poses++;
    if (wp_count < 2) begin
      res.lat = '0;
      res.hdg = '0;
      res.st = 1'b1;
    end else begin
      res = nearest_error(r.x, r.y, r.hdg);
    end
    wp_count = 0;
    frenet_q.push_back(res);
  endfunction

  function automatic void push_req(pfe_pkg::kind_e k, longint x, longint y, longint h);
    request_t r;
    r.kind = k;
    r.x = x[31:0];
    r.y = y[31:0];
    r.hdg = h[18:0];
    pending_q.push_back(r);
  endfunction

  function automatic longint rand_hdg();
    case ($urandom_range(0, 9))
      0: return 205887;
      1: return -205887;
      default: return longint'($urandom_range(0, 411774)) - 205887;
    endcase
  endfunction

  function automatic longint rand_coord(longint base);
    case ($urandom_range(0, 19))
      0: return -64'sd2147483648;
      1: return 64'sd2147483647;
      2: return longint'(int'($urandom()));
      default: return base + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
  endfunction

  // random path: mostly a connected walk, sometimes repeated points or junk
  function automatic void push_path();
    longint bx, by, cx, cy;
    int n;
    bx = longint'(int'($urandom())) >>> $urandom_range(0, 8);
    by = longint'(int'($urandom())) >>> $urandom_range(0, 8);
    cx = bx;
    cy = by;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(0, 1);
      1: n = $urandom_range(17, 20);
      default: n = $urandom_range(2, 12);
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_req(pfe_pkg::KIND_WAYPOINT, cx, cy, rand_hdg());
      end else if ($urandom_range(0, 15) == 0) begin
        push_req(pfe_pkg::KIND_WAYPOINT, rand_coord(cx), rand_coord(cy), rand_hdg());
      end else begin
        cx = cx + longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        cy = cy + longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        if (cx > DMax || cx < -DMax) cx = bx;
        if (cy > DMax || cy < -DMax) cy = by;
        push_req(pfe_pkg::KIND_WAYPOINT, cx, cy, rand_hdg());
      end
    end
    push_req(pfe_pkg::KIND_POSE, rand_coord(cx), rand_coord(cy), rand_hdg());
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      taken <= start_i && !busy_o;
      if (valid_o) begin
        n_results++;
        if (frenet_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result at %0t", $time);
          mismatches++;
        end else begin
          frenet_t e;
          e = frenet_q.pop_front();
          if (e.st) n_short++;
          if (lateral_error_o !== e.lat || heading_error_o !== e.hdg || status_o !== e.st)
          begin
            if (mismatches < 10)
              $display("mismatch at %0t: exp lat %0d hdg %0d st %0b, got lat %0d hdg %0d st %0b",
                       $time, e.lat, e.hdg, e.st, lateral_error_o, heading_error_o, status_o);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o)
        apply_request('{req_type_i ? pfe_pkg::KIND_POSE : pfe_pkg::KIND_WAYPOINT,
                        pos_x_i, pos_y_i, heading_i});
    end
  end

  always @(negedge clk_i) begin
    bit nxt;
    request_t r;
    if (rst_ni) begin
      nxt = start_i;
      if (taken) nxt = 1'b0;
      if (!nxt) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_q.size() != 0) begin
          r = pending_q.pop_front();
          req_type_i <= (r.kind == pfe_pkg::KIND_POSE);
          pos_x_i <= r.x;
          pos_y_i <= r.y;
          heading_i <= r.hdg;
          nxt = 1'b1;
          if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
          gap_cnt = no_idle ? 0 : $urandom_range(0, 12);
        end
      end
      start_i <= nxt;
    end
  end

  initial begin
    // empty store, then a single waypoint: both too few
    push_req(pfe_pkg::KIND_POSE, 0, 0, 0);
    push_req(pfe_pkg::KIND_WAYPOINT, 100, 200, 205887);
    push_req(pfe_pkg::KIND_POSE, -64'sd2147483648, 64'sd2147483647, -205887);
    // degenerate segment and heading extremes
    push_req(pfe_pkg::KIND_WAYPOINT, 65536, 65536, 205887);
    push_req(pfe_pkg::KIND_WAYPOINT, 65536, 65536, -205887);
    push_req(pfe_pkg::KIND_POSE, 0, 131072, 205887);
    // extreme coordinates: saturated differences and clamped projection
    push_req(pfe_pkg::KIND_WAYPOINT, -64'sd2147483648, -64'sd2147483648, -205887);
    push_req(pfe_pkg::KIND_WAYPOINT, 64'sd2147483647, 64'sd2147483647, 205887);
    push_req(pfe_pkg::KIND_WAYPOINT, -64'sd2147483648, 64'sd2147483647, 0);
    push_req(pfe_pkg::KIND_POSE, 64'sd2147483647, -64'sd2147483648, -205887);
    // equal segments to tie the distance, then a full store with drops
    for (int i = 0; i < 19; i++)
      push_req(pfe_pkg::KIND_WAYPOINT, (i % 2) * 65536, 0, (i % 2) ? 205887 : -205887);
    push_req(pfe_pkg::KIND_POSE, 32768, -65536, 0);
    for (int i = 0; i < NumRandom;) begin
      int before_n;
      before_n = pending_q.size();
      push_path();
      i += pending_q.size() - before_n;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (pending_q.size() == 0 && !start_i && frenet_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("covered %0d waypoint and %0d pose requests, %0d results (%0d too-few)",
             n_waypoints, n_poses, n_results, n_short);
    if (mismatches == 0 && frenet_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule
